[sv/mesh_element_level_ordering_assert.svh]
// Assertion macros for the mesh element level ordering block.
// Used by the port checker; needs clk and rst_n in the including scope.
`ifndef MESH_ELEMENT_LEVEL_ORDERING_ASSERT_SVH
`define MESH_ELEMENT_LEVEL_ORDERING_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define MELO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MELO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/melo_pkg.sv]
// Shared types and constants for the mesh element level ordering block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package melo_pkg;

  localparam int MAX_NODES          = 4096;
  localparam int MAX_ELEMENTS       = 8192;
  localparam int MAX_ELEMS_PER_NODE = 16;
  localparam int MAX_NODES_PER_ELEM = 8;

  localparam logic [2:0] OP_COORD  = 3'd0;
  localparam logic [2:0] OP_INC    = 3'd1;
  localparam logic [2:0] OP_CNT    = 3'd2;
  localparam logic [2:0] OP_ENODE  = 3'd3;
  localparam logic [2:0] OP_START  = 3'd4;
  localparam logic [2:0] OP_READ   = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DONE   = 2'd1;
  localparam logic [1:0] ST_STALL  = 2'd2;

  localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [1:0] CFG_ELEM_COUNT = 2'd1;
  localparam logic [1:0] CFG_NPE        = 2'd2;

  typedef struct packed {
    logic [2:0]         op;
    logic [12:0]        node_num;
    logic [13:0]        elem_num;
    logic [3:0]         slot;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic [4:0]         incidence_count;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] rank;
    logic [13:0] elem_at_rank;
    logic [12:0] seed_node;
  } result_t;

  // Register values already clamped into their legal ranges.
  typedef struct packed {
    logic [12:0] nc;
    logic [13:0] ne;
    logic [3:0]  npe;
  } cfg_t;

endpackage

[sv/melo_core.sv]
// Table memories and the seed search / level walk sequencer.
// Depends on melo_pkg.
`timescale 1ns / 1ps

module melo_core import melo_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    acc,
  input  item_t   item,
  input  cfg_t    cfg,
  output logic    idle,
  output logic    done,
  output result_t res
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_CLR     = 5'd1;
  localparam logic [4:0] S_SEED_A  = 5'd2;
  localparam logic [4:0] S_SEED_B  = 5'd3;
  localparam logic [4:0] S_INIT    = 5'd4;
  localparam logic [4:0] S_LVL     = 5'd5;
  localparam logic [4:0] S_NF_A    = 5'd6;
  localparam logic [4:0] S_NF_B    = 5'd7;
  localparam logic [4:0] S_CNT     = 5'd8;
  localparam logic [4:0] S_IL_A    = 5'd9;
  localparam logic [4:0] S_IL_B    = 5'd10;
  localparam logic [4:0] S_RK      = 5'd11;
  localparam logic [4:0] S_LVL_END = 5'd12;
  localparam logic [4:0] S_EF_A    = 5'd13;
  localparam logic [4:0] S_EF_B    = 5'd14;
  localparam logic [4:0] S_EN_A    = 5'd15;
  localparam logic [4:0] S_EN_B    = 5'd16;
  localparam logic [4:0] S_MK      = 5'd17;
  localparam logic [4:0] S_RD_A    = 5'd18;
  localparam logic [4:0] S_RD_B    = 5'd19;
  localparam logic [4:0] S_FIN     = 5'd20;

  logic [4:0]  state_r, state_nxt;
  logic        go_r, go_nxt;
  logic [13:0] clr_r, clr_nxt;
  logic [13:0] i_r, i_nxt;
  logic [4:0]  j_r, j_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [11:0] node_r, node_nxt;
  logic [13:0] e_r, e_nxt;
  logic [12:0] n_r, n_nxt;
  logic [13:0] num_r, num_nxt;
  logic [13:0] level_r, level_nxt;
  logic [12:0] nf_len_r, nf_len_nxt;
  logic [13:0] ef_len_r, ef_len_nxt;
  logic [12:0] seed_r, seed_nxt;
  logic signed [31:0] xmin_r, xmin_nxt, ymin_r, ymin_nxt;
  logic [13:0] elem_r, elem_nxt;
  result_t     res_r, res_nxt;

  logic [63:0] xy_mem   [0:MAX_NODES-1];
  logic [4:0]  cnt_mem  [0:MAX_NODES-1];
  logic [13:0] il_mem   [0:MAX_NODES*MAX_ELEMS_PER_NODE-1];
  logic [12:0] en_mem   [0:MAX_ELEMENTS*MAX_NODES_PER_ELEM-1];
  logic [13:0] rank_mem [0:MAX_ELEMENTS-1];
  logic [13:0] pos_mem  [0:MAX_ELEMENTS-1];
  logic [13:0] ef_mem   [0:MAX_ELEMENTS-1];
  logic [12:0] nf_mem   [0:MAX_NODES-1];
  logic [13:0] mark_mem [0:MAX_NODES-1];

  logic        xy_we, cnt_we, il_we, en_we, rank_we, pos_we, ef_we, nf_we, mark_we;
  logic [11:0] xy_wa, cnt_wa, nf_wa, mark_wa, xy_ra, cnt_ra, nf_ra, mark_ra;
  logic [15:0] il_wa, en_wa, il_ra, en_ra;
  logic [12:0] rank_wa, pos_wa, ef_wa, rank_ra, pos_ra, ef_ra;
  logic [4:0]  cnt_wd;
  logic [13:0] rank_wd, pos_wd, mark_wd;
  logic [12:0] nf_wd;
  logic [63:0] xy_rd;
  logic [4:0]  cnt_rd;
  logic [12:0] en_rd, nf_rd;
  logic [13:0] il_rd, rank_rd, pos_rd, ef_rd, mark_rd;

  logic        node_ok, elem_ok, ld, e_ok, n_ok, new_rank, new_node, x_le, y_le;
  logic [12:0] node_m1;
  logic [13:0] elem_m1, il_m1, en_m1, nf_m1, e_m1, n_m1, elem_r_m1;
  logic signed [31:0] x_rd, y_rd;

  always_ff @(posedge clk) begin
    if (xy_we) xy_mem[xy_wa] <= {item.coord_x, item.coord_y};
    xy_rd <= xy_mem[xy_ra];
  end
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_rd <= cnt_mem[cnt_ra];
  end
  always_ff @(posedge clk) begin
    if (il_we) il_mem[il_wa] <= item.elem_num;
    il_rd <= il_mem[il_ra];
  end
  always_ff @(posedge clk) begin
    if (en_we) en_mem[en_wa] <= item.node_num;
    en_rd <= en_mem[en_ra];
  end
  always_ff @(posedge clk) begin
    if (rank_we) rank_mem[rank_wa] <= rank_wd;
    rank_rd <= rank_mem[rank_ra];
  end
  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    pos_rd <= pos_mem[pos_ra];
  end
  always_ff @(posedge clk) begin
    if (ef_we) ef_mem[ef_wa] <= e_r;
    ef_rd <= ef_mem[ef_ra];
  end
  always_ff @(posedge clk) begin
    if (nf_we) nf_mem[nf_wa] <= nf_wd;
    nf_rd <= nf_mem[nf_ra];
  end
  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    mark_rd <= mark_mem[mark_ra];
  end

  always_comb begin
    node_m1   = item.node_num - 13'd1;
    elem_m1   = item.elem_num - 14'd1;
    il_m1     = il_rd - 14'd1;
    en_m1     = {1'b0, en_rd} - 14'd1;
    nf_m1     = {1'b0, nf_rd} - 14'd1;
    e_m1      = e_r - 14'd1;
    n_m1      = {1'b0, n_r} - 14'd1;
    elem_r_m1 = elem_r - 14'd1;
    x_rd      = $signed(xy_rd[63:32]);
    y_rd      = $signed(xy_rd[31:0]);
    x_le      = xmin_r >= x_rd;
    y_le      = ymin_r >= y_rd;
    ld        = acc && (state_r == S_IDLE);
    node_ok   = (item.node_num != 13'd0) && (item.node_num <= 13'(MAX_NODES));
    elem_ok   = (item.elem_num != 14'd0) && (item.elem_num <= 14'(MAX_ELEMENTS));
    e_ok      = (il_rd != 14'd0) && (il_rd <= cfg.ne);
    n_ok      = (en_rd != 13'd0) && (en_rd <= cfg.nc);
    new_rank  = (state_r == S_RK) && (rank_rd == 14'd0);
    new_node  = (state_r == S_MK) && (mark_rd != level_r);

    xy_we  = ld && (item.op == OP_COORD) && node_ok;
    xy_wa  = node_m1[11:0];
    xy_ra  = i_r[11:0];

    cnt_we = ld && (item.op == OP_CNT) && node_ok;
    cnt_wa = node_m1[11:0];
    cnt_wd = (item.incidence_count > 5'(MAX_ELEMS_PER_NODE)) ?
             5'(MAX_ELEMS_PER_NODE) : item.incidence_count;
    cnt_ra = nf_m1[11:0];

    il_we  = ld && (item.op == OP_INC) && node_ok;
    il_wa  = {node_m1[11:0], item.slot};
    il_ra  = {node_r, j_r[3:0]};

    en_we  = ld && (item.op == OP_ENODE) && elem_ok && !item.slot[3];
    en_wa  = {elem_m1[12:0], item.slot[2:0]};
    en_ra  = {e_m1[12:0], j_r[2:0]};

    rank_we = (state_r == S_CLR) || new_rank;
    rank_wa = (state_r == S_CLR) ? clr_r[12:0] : e_m1[12:0];
    rank_wd = (state_r == S_CLR) ? 14'd0 : num_r + 14'd1;
    rank_ra = (state_r == S_IL_B) ? il_m1[12:0] : elem_r_m1[12:0];

    pos_we  = (state_r == S_CLR) || new_rank;
    pos_wa  = (state_r == S_CLR) ? clr_r[12:0] : num_r[12:0];
    pos_wd  = (state_r == S_CLR) ? 14'd0 : e_r;
    pos_ra  = elem_r_m1[12:0];

    ef_we   = new_rank;
    ef_wa   = ef_len_r[12:0];
    ef_ra   = i_r[12:0];

    nf_we   = (state_r == S_INIT) || new_node;
    nf_wa   = (state_r == S_INIT) ? 12'd0 : nf_len_r[11:0];
    nf_wd   = (state_r == S_INIT) ? seed_r : n_r;
    nf_ra   = i_r[11:0];

    mark_we = ((state_r == S_CLR) && !clr_r[13] && !clr_r[12]) || new_node;
    mark_wa = (state_r == S_CLR) ? clr_r[11:0] : n_m1[11:0];
    mark_wd = (state_r == S_CLR) ? 14'd0 : level_r;
    mark_ra = en_m1[11:0];
  end

  always_comb begin
    state_nxt  = state_r;
    go_nxt     = go_r;
    clr_nxt    = clr_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    cnt_nxt    = cnt_r;
    node_nxt   = node_r;
    e_nxt      = e_r;
    n_nxt      = n_r;
    num_nxt    = num_r;
    level_nxt  = level_r;
    nf_len_nxt = nf_len_r;
    ef_len_nxt = ef_len_r;
    seed_nxt   = seed_r;
    xmin_nxt   = xmin_r;
    ymin_nxt   = ymin_r;
    elem_nxt   = elem_r;
    res_nxt    = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc && item.op == OP_START) begin
          go_nxt    = 1'b1;
          clr_nxt   = '0;
          state_nxt = S_CLR;
        end else if (acc && item.op == OP_READ) begin
          elem_nxt  = item.elem_num;
          state_nxt = S_RD_A;
        end
      end
      S_CLR: begin
        clr_nxt = clr_r + 14'd1;
        if (clr_r == 14'(MAX_ELEMENTS - 1)) begin
          i_nxt     = '0;
          state_nxt = go_r ? S_SEED_A : S_IDLE;
          go_nxt    = 1'b0;
        end
      end
      S_SEED_A: state_nxt = S_SEED_B;
      S_SEED_B: begin
        if (i_r == 14'd0 || (x_le && y_le)) begin
          seed_nxt = i_r[12:0] + 13'd1;
          xmin_nxt = x_rd;
          ymin_nxt = y_rd;
        end
        i_nxt = i_r + 14'd1;
        state_nxt = (i_r + 14'd1 == {1'b0, cfg.nc}) ? S_INIT : S_SEED_A;
      end
      S_INIT: begin
        num_nxt    = '0;
        level_nxt  = '0;
        nf_len_nxt = 13'd1;
        state_nxt  = S_LVL;
      end
      S_LVL: begin
        if (num_r >= cfg.ne) begin
          res_nxt   = '{status: ST_DONE, rank: '0, elem_at_rank: '0, seed_node: seed_r};
          state_nxt = S_FIN;
        end else begin
          ef_len_nxt = '0;
          i_nxt      = '0;
          state_nxt  = S_NF_A;
        end
      end
      S_NF_A: state_nxt = (i_r == {1'b0, nf_len_r}) ? S_LVL_END : S_NF_B;
      S_NF_B: begin
        node_nxt  = nf_m1[11:0];
        state_nxt = S_CNT;
      end
      S_CNT: begin
        cnt_nxt   = cnt_rd;
        j_nxt     = '0;
        state_nxt = S_IL_A;
      end
      S_IL_A: begin
        if (j_r == cnt_r) begin
          i_nxt     = i_r + 14'd1;
          state_nxt = S_NF_A;
        end else begin
          state_nxt = S_IL_B;
        end
      end
      S_IL_B: begin
        if (e_ok) begin
          e_nxt     = il_rd;
          state_nxt = S_RK;
        end else begin
          j_nxt     = j_r + 5'd1;
          state_nxt = S_IL_A;
        end
      end
      S_RK: begin
        if (new_rank) begin
          num_nxt    = num_r + 14'd1;
          ef_len_nxt = ef_len_r + 14'd1;
        end
        j_nxt     = j_r + 5'd1;
        state_nxt = S_IL_A;
      end
      S_LVL_END: begin
        if (ef_len_r == 14'd0) begin
          res_nxt   = '{status: ST_STALL, rank: '0, elem_at_rank: '0, seed_node: seed_r};
          state_nxt = S_FIN;
        end else begin
          level_nxt  = level_r + 14'd1;
          nf_len_nxt = '0;
          i_nxt      = '0;
          state_nxt  = S_EF_A;
        end
      end
      S_EF_A: state_nxt = (i_r == ef_len_r) ? S_LVL : S_EF_B;
      S_EF_B: begin
        e_nxt     = ef_rd;
        j_nxt     = '0;
        state_nxt = S_EN_A;
      end
      S_EN_A: begin
        if (j_r == {1'b0, cfg.npe}) begin
          i_nxt     = i_r + 14'd1;
          state_nxt = S_EF_A;
        end else begin
          state_nxt = S_EN_B;
        end
      end
      S_EN_B: begin
        if (n_ok) begin
          n_nxt     = en_rd;
          state_nxt = S_MK;
        end else begin
          j_nxt     = j_r + 5'd1;
          state_nxt = S_EN_A;
        end
      end
      S_MK: begin
        if (new_node) nf_len_nxt = nf_len_r + 13'd1;
        j_nxt     = j_r + 5'd1;
        state_nxt = S_EN_A;
      end
      S_RD_A: state_nxt = S_RD_B;
      S_RD_B: begin
        res_nxt = '0;
        if (elem_r != 14'd0 && elem_r <= cfg.ne) begin
          res_nxt.rank         = rank_rd;
          res_nxt.elem_at_rank = pos_rd;
        end
        state_nxt = S_FIN;
      end
      S_FIN: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      go_r    <= 1'b0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      go_r    <= go_nxt;
      clr_r   <= clr_nxt;
    end
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    cnt_r    <= cnt_nxt;
    node_r   <= node_nxt;
    e_r      <= e_nxt;
    n_r      <= n_nxt;
    num_r    <= num_nxt;
    level_r  <= level_nxt;
    nf_len_r <= nf_len_nxt;
    ef_len_r <= ef_len_nxt;
    seed_r   <= seed_nxt;
    xmin_r   <= xmin_nxt;
    ymin_r   <= ymin_nxt;
    elem_r   <= elem_nxt;
    res_r    <= res_nxt;
  end

  assign idle = (state_r == S_IDLE);
  assign done = (state_r == S_FIN);
  assign res  = res_r;

endmodule

[sv/mesh_element_level_ordering.sv]
// Top level of the mesh element level ordering block: handshakes,
// configuration registers and output register. Depends on melo_pkg, melo_core.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    op, node, elem, slot, coords, count
//   out_     output     out_valid/out_ready  status, rank, elem_at_rank, seed
//   cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Loads and unused ops are answered in the cycle after they are taken; a read goes
// through the rank and position memories. A start clears those memories, scans
// node_count coordinates to find the seed, then walks the mesh level by level.
// After reset the same clearing pass runs before in_ready rises; configuration
// writes are always taken.
`timescale 1ns / 1ps

module mesh_element_level_ordering import melo_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_op,
  input  logic [12:0]        in_node_num,
  input  logic [13:0]        in_elem_num,
  input  logic [3:0]         in_slot,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic [4:0]         in_incidence_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [13:0]        out_rank,
  output logic [13:0]        out_elem_at_rank,
  output logic [12:0]        out_seed_node,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [13:0]        cfg_data
);

  logic [12:0] node_count_r;
  logic [13:0] elem_count_r;
  logic [3:0]  npe_r;
  logic        out_valid_r;
  result_t     out_res_r;
  cfg_t        cfg;
  item_t       item;
  logic        core_idle, core_done, in_acc, short_op;
  result_t     core_res;

  always_comb begin
    item = '{op: in_op, node_num: in_node_num, elem_num: in_elem_num, slot: in_slot,
             coord_x: in_coord_x, coord_y: in_coord_y,
             incidence_count: in_incidence_count};
    cfg.nc  = (node_count_r == 13'd0) ? 13'd1 :
              (node_count_r > 13'(MAX_NODES)) ? 13'(MAX_NODES) : node_count_r;
    cfg.ne  = (elem_count_r == 14'd0) ? 14'd1 :
              (elem_count_r > 14'(MAX_ELEMENTS)) ? 14'(MAX_ELEMENTS) : elem_count_r;
    cfg.npe = (npe_r == 4'd0) ? 4'd1 :
              (npe_r > 4'(MAX_NODES_PER_ELEM)) ? 4'(MAX_NODES_PER_ELEM) : npe_r;
  end

  assign in_ready  = core_idle && (!out_valid_r || out_ready);
  assign in_acc    = in_valid && in_ready;
  assign short_op  = (in_op != OP_START) && (in_op != OP_READ);
  assign cfg_ready = 1'b1;

  melo_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (in_acc),
    .item  (item),
    .cfg   (cfg),
    .idle  (core_idle),
    .done  (core_done),
    .res   (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= 13'd1;
      elem_count_r <= 14'd1;
      npe_r        <= 4'd3;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_NODE_COUNT: node_count_r <= cfg_data[12:0];
        CFG_ELEM_COUNT: elem_count_r <= cfg_data;
        CFG_NPE:        npe_r        <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Loads answer at once; starts and reads answer when the core finishes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && short_op) begin
      out_valid_r <= 1'b1;
    end else if (core_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (in_acc && short_op) begin
      out_res_r <= '0;
    end else if (core_done) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_res_r.status;
  assign out_rank         = out_res_r.rank;
  assign out_elem_at_rank = out_res_r.elem_at_rank;
  assign out_seed_node    = out_res_r.seed_node;

endmodule

[sv/melo_chk.sv]
// Port-level checker for the mesh element level ordering block, with its bind.
// Depends on melo_pkg and mesh_element_level_ordering_assert.svh.
`timescale 1ns / 1ps
`include "mesh_element_level_ordering_assert.svh"

module melo_chk import melo_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [2:0]  in_op,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [13:0] out_rank,
  input logic [12:0] out_seed_node
);

  `MELO_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `MELO_ASSERT_NOW(a_status_code, out_valid, out_status != 2'd3, "illegal status code")
  `MELO_ASSERT_NEXT(a_load_answer, in_valid && in_ready && in_op != OP_START && in_op != OP_READ, out_valid && out_status == ST_OK && out_seed_node == 13'd0, "load transaction not answered next cycle")
  `MELO_ASSERT_NOW(a_walk_seed, out_valid && out_status != ST_OK, out_seed_node != 13'd0 && out_rank == 14'd0, "walk result without seed")

endmodule

bind mesh_element_level_ordering melo_chk u_melo_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_op         (in_op),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_status    (out_status),
  .out_rank      (out_rank),
  .out_seed_node (out_seed_node)
);
